>>> rtl/mme_pkg.sv
`default_nettype none

package mme_pkg;

    localparam int DIM_W     = 7;
    localparam int IN_IDX_W  = 6;
    localparam int VAL_W     = 16;
    localparam int ACC_W     = 40;
    localparam int COL_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ELEM = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ROW  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic [DIM_W-1:0] a_rows;
        logic [DIM_W-1:0] a_cols;
        logic [DIM_W-1:0] b_rows;
        logic [DIM_W-1:0] b_cols;
    } dims_t;

    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/mme_ram.sv
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mme_mac.sv
`default_nettype none

module mme_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mme_pkg::mac_ctrl_t            ctrl,
    input  wire logic signed [ELEM_WIDTH-1:0]  a_data,
    input  wire logic signed [ELEM_WIDTH-1:0]  b_data,
    output logic [mme_pkg::ACC_W-1:0]          acc,
    output logic                               busy
);

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int EXT_W  = (PROD_W > mme_pkg::ACC_W) ? PROD_W : mme_pkg::ACC_W;

    logic                        data_v_reg;
    logic                        prod_v_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [EXT_W-1:0]     prod_ext;
    logic [mme_pkg::ACC_W-1:0]   acc_reg;
    logic [mme_pkg::ACC_W-1:0]   acc_next;

    assign prod_ext = EXT_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + prod_ext[mme_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            data_v_reg <= ctrl.issue;
            prod_v_reg <= data_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_data * b_data;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = data_v_reg | prod_v_reg;

endmodule

`default_nettype wire

>>> rtl/mme_seq.sv
`default_nettype none

module mme_seq #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mme_pkg::dims_t                      dims,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [mme_pkg::REQ_W-1:0]           req_type,
    input  wire logic [mme_pkg::IN_IDX_W-1:0]        row_index,
    input  wire logic [mme_pkg::IN_IDX_W-1:0]        col_index,
    input  wire logic signed [mme_pkg::VAL_W-1:0]    value,
    output mme_pkg::mac_ctrl_t                       mac_ctrl,
    input  wire logic                                mac_busy,
    input  wire logic [mme_pkg::ACC_W-1:0]           acc,
    output logic                                     a_we,
    output logic                                     b_we,
    output logic [2*$clog2(MAX_DIM)-1:0]             waddr,
    output logic [ELEM_WIDTH-1:0]                    wdata,
    output logic [2*$clog2(MAX_DIM)-1:0]             a_raddr,
    output logic [2*$clog2(MAX_DIM)-1:0]             b_raddr,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [mme_pkg::ACC_W-1:0]         product_value,
    output logic [mme_pkg::COL_W-1:0]                out_col,
    output logic                                     last,
    output logic [mme_pkg::STATUS_W-1:0]             status
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CMP_W = ($clog2(MAX_DIM + 1) > mme_pkg::DIM_W)
                           ? $clog2(MAX_DIM + 1) : mme_pkg::DIM_W;
    localparam int VW    = (ELEM_WIDTH < mme_pkg::VAL_W) ? ELEM_WIDTH : mme_pkg::VAL_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIM);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MAC   = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                row_reg, row_next;
    logic [IDX_W-1:0]                col_reg, col_next;
    logic [IDX_W-1:0]                k_reg, k_next;
    logic [mme_pkg::COL_W-1:0]       req_col_reg, req_col_next;
    logic                            is_row_reg, is_row_next;
    logic [mme_pkg::STATUS_W-1:0]    st_reg, st_next;
    logic                            ov_reg, ov_next;
    logic [mme_pkg::ACC_W-1:0]       prod_out_reg, prod_out_next;
    logic [mme_pkg::COL_W-1:0]       ocol_reg, ocol_next;
    logic                            last_reg, last_next;

    logic [CMP_W-1:0] eff_a_rows, eff_a_cols, eff_b_rows, eff_b_cols;
    logic [CMP_W-1:0] row_c, col_c;
    logic             k_last, col_last, res_last, slot_free, mismatch, range_err, is_row_req;

    assign row_c = CMP_W'(row_index);
    assign col_c = CMP_W'(col_index);

    assign eff_a_rows = (CMP_W'(dims.a_rows) > MAX_C) ? MAX_C : CMP_W'(dims.a_rows);
    assign eff_a_cols = (CMP_W'(dims.a_cols) > MAX_C) ? MAX_C : CMP_W'(dims.a_cols);
    assign eff_b_rows = (CMP_W'(dims.b_rows) > MAX_C) ? MAX_C : CMP_W'(dims.b_rows);
    assign eff_b_cols = (CMP_W'(dims.b_cols) > MAX_C) ? MAX_C : CMP_W'(dims.b_cols);

    assign k_last    = (CMP_W'(k_reg) + CMP_W'(1)) == eff_a_cols;
    assign col_last  = (CMP_W'(col_reg) + CMP_W'(1)) == eff_b_cols;
    assign res_last  = (st_reg != mme_pkg::ST_OK) || !is_row_reg || col_last;
    assign slot_free = !ov_reg || out_ready;

    assign is_row_req = (req_type == mme_pkg::REQ_ROW);
    assign mismatch   = (dims.a_cols != dims.b_rows);
    assign range_err  = (row_c >= eff_a_rows) ||
                        (is_row_req ? (eff_b_cols == '0) : (col_c >= eff_b_cols));

    assign waddr   = {IDX_W'(row_index), IDX_W'(col_index)};
    assign wdata   = ELEM_WIDTH'($signed(value[VW-1:0]));
    assign a_raddr = {row_reg, k_reg};
    assign b_raddr = {k_reg, col_reg};

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        req_col_next  = req_col_reg;
        is_row_next   = is_row_reg;
        st_next       = st_reg;
        ov_next       = ov_reg && !out_ready;
        prod_out_next = prod_out_reg;
        ocol_next     = ocol_reg;
        last_next     = last_reg;
        mac_ctrl      = '0;
        a_we          = 1'b0;
        b_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type) inside
                        mme_pkg::REQ_WR_A:
                        begin
                            a_we = (row_c < eff_a_rows) && (col_c < eff_a_cols);
                        end
                        mme_pkg::REQ_WR_B:
                        begin
                            b_we = (row_c < eff_b_rows) && (col_c < eff_b_cols);
                        end
                        mme_pkg::REQ_ELEM, mme_pkg::REQ_ROW:
                        begin
                            row_next       = IDX_W'(row_index);
                            is_row_next    = is_row_req;
                            req_col_next   = col_index;
                            col_next       = is_row_req ? '0 : IDX_W'(col_index);
                            k_next         = '0;
                            mac_ctrl.clear = 1'b1;
                            if (mismatch)
                            begin
                                st_next    = mme_pkg::ST_MISMATCH;
                                state_next = S_DRAIN;
                            end
                            else if (range_err)
                            begin
                                st_next    = mme_pkg::ST_RANGE;
                                state_next = S_DRAIN;
                            end
                            else
                            begin
                                st_next    = mme_pkg::ST_OK;
                                state_next = (eff_a_cols == '0) ? S_DRAIN : S_MAC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                mac_ctrl.issue = 1'b1;
                k_next         = k_reg + IDX_W'(1);
                if (k_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy && slot_free)
                begin
                    ov_next       = 1'b1;
                    prod_out_next = acc;
                    ocol_next     = is_row_reg ? mme_pkg::COL_W'(col_reg) : req_col_reg;
                    last_next     = res_last;
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next       = col_reg + IDX_W'(1);
                        k_next         = '0;
                        mac_ctrl.clear = 1'b1;
                        state_next     = (eff_a_cols == '0) ? S_DRAIN : S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        k_reg        <= k_next;
        req_col_reg  <= req_col_next;
        is_row_reg   <= is_row_next;
        st_reg       <= st_next;
        prod_out_reg <= prod_out_next;
        ocol_reg     <= ocol_next;
        last_reg     <= last_next;
    end

    // status of the held result tracks the request that produced it
    logic [mme_pkg::STATUS_W-1:0] st_out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DRAIN && !mac_busy && slot_free)
        begin
            st_out_reg <= st_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign product_value = $signed(prod_out_reg);
    assign out_col       = ocol_reg;
    assign last          = last_reg;
    assign status        = st_out_reg;

endmodule

`default_nettype wire

>>> rtl/matrix_multiply_engine.sv
// Matrix multiply engine: holds matrices A and B and returns dot products of A*B.
// Input channel (in_valid/in_ready) carries one request per transfer:
//   write A or B element (no result), compute one element
//   (one result), or compute a whole row (one result per column, last on the end).
// Output channel (out_valid/out_ready) carries product_value, out_col, last, status.
// Dimensions are set through cfg_we/cfg_index/cfg_data; the user must write them
// only while the engine is idle, which the block itself does not enforce.
// Each result element is a multiply-accumulate over the inner dimension a_cols
// through one shared multiplier, where the loop over the inner dimension reads one A
// and one B element per cycle from the two element memories; when the inner
// dimension is zero the loop is skipped.
// Error results (dimension mismatch, index out of range) also skip the loop.
// in_ready is high only while no compute request is in progress.
// The result register holds its value while out_ready is low; the engine
// stalls before loading the next result and resumes when it is taken.
// Reset clears control state and sets all dimensions to 64; element
// memories are not cleared and must be written before they are read.
`default_nettype none

module matrix_multiply_engine #(
    parameter int MAX_DIM    = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mme_pkg::DIM_W-1:0]           cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [mme_pkg::REQ_W-1:0]           req_type,
    input  wire logic [mme_pkg::IN_IDX_W-1:0]        row_index,
    input  wire logic [mme_pkg::IN_IDX_W-1:0]        col_index,
    input  wire logic signed [mme_pkg::VAL_W-1:0]    value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [mme_pkg::ACC_W-1:0]         product_value,
    output logic [mme_pkg::COL_W-1:0]                out_col,
    output logic                                     last,
    output logic [mme_pkg::STATUS_W-1:0]             status
);

    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    mme_pkg::dims_t     dims_reg;
    mme_pkg::mac_ctrl_t mac_ctrl;
    logic               mac_busy;
    logic [mme_pkg::ACC_W-1:0] acc;
    logic               a_we, b_we;
    logic [ADDR_W-1:0]  waddr, a_raddr, b_raddr;
    logic [ELEM_WIDTH-1:0] wdata, a_rdata, b_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.a_rows <= mme_pkg::DIM_RESET;
            dims_reg.a_cols <= mme_pkg::DIM_RESET;
            dims_reg.b_rows <= mme_pkg::DIM_RESET;
            dims_reg.b_cols <= mme_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mme_pkg::CFG_A_ROWS: dims_reg.a_rows <= cfg_data;
                mme_pkg::CFG_A_COLS: dims_reg.a_cols <= cfg_data;
                mme_pkg::CFG_B_ROWS: dims_reg.b_rows <= cfg_data;
                mme_pkg::CFG_B_COLS: dims_reg.b_cols <= cfg_data;
            endcase
        end
    end

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mme_mac #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .acc    (acc),
        .busy   (mac_busy)
    );

    mme_seq #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .dims          (dims_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .mac_ctrl      (mac_ctrl),
        .mac_busy      (mac_busy),
        .acc           (acc),
        .a_we          (a_we),
        .b_we          (b_we),
        .waddr         (waddr),
        .wdata         (wdata),
        .a_raddr       (a_raddr),
        .b_raddr       (b_raddr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .product_value (product_value),
        .out_col       (out_col),
        .last          (last),
        .status        (status)
    );

endmodule

`default_nettype wire

>>> bench/mme_product_check.sv
`timescale 1ns / 1ps

module mme_product_check
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [DIM_W-1:0]              cfg_data,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [REQ_W-1:0]              req_type,
    input  wire logic [IN_IDX_W-1:0]           row_index,
    input  wire logic [IN_IDX_W-1:0]           col_index,
    input  wire logic signed [VAL_W-1:0]       value,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [ACC_W-1:0]       product_value,
    input  wire logic [COL_W-1:0]              out_col,
    input  wire logic                          last,
    input  wire logic [STATUS_W-1:0]           status,
    output int                                 pending,
    output int                                 errors
);

    typedef struct packed {
        logic [ACC_W-1:0]    prod;
        logic [COL_W-1:0]    col;
        logic                last;
        logic [STATUS_W-1:0] st;
    } product_t;

    product_t                product_q[$];
    product_t                oldest;
    dims_t                   dims;
    logic signed [VAL_W-1:0] a_mem [0:MAX_DIM*MAX_DIM-1];
    logic signed [VAL_W-1:0] b_mem [0:MAX_DIM*MAX_DIM-1];

    function automatic int clamp_dim(logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic logic [ACC_W-1:0] dot_product(int r, int c);
        longint sum;
        int     k;
        sum = 0;
        for (k = 0; k < clamp_dim(dims.a_cols); k++)
        begin
            sum += longint'(a_mem[r*MAX_DIM+k]) * longint'(b_mem[k*MAX_DIM+c]);
        end
        return sum[ACC_W-1:0];
    endfunction

    function automatic product_t make_product(logic [ACC_W-1:0] p, int c, logic l,
                                              logic [STATUS_W-1:0] s);
        product_t e;
        e.prod = p;
        e.col  = c[COL_W-1:0];
        e.last = l;
        e.st   = s;
        return e;
    endfunction

    task automatic predict_products(input logic [REQ_W-1:0] rq, input int r, input int c,
                                    input logic signed [VAL_W-1:0] v);
        int ncol;
        int j;
        ncol = clamp_dim(dims.b_cols);
        if (rq == REQ_WR_A)
        begin
            if (r < clamp_dim(dims.a_rows) && c < clamp_dim(dims.a_cols))
                a_mem[r*MAX_DIM+c] = v;
        end
        else if (rq == REQ_WR_B)
        begin
            if (r < clamp_dim(dims.b_rows) && c < ncol)
                b_mem[r*MAX_DIM+c] = v;
        end
        else if (dims.a_cols != dims.b_rows)
        begin
            product_q.push_back(make_product('0, (rq == REQ_ELEM) ? c : 0, 1'b1, ST_MISMATCH));
        end
        else if (rq == REQ_ELEM)
        begin
            if (r >= clamp_dim(dims.a_rows) || c >= ncol)
                product_q.push_back(make_product('0, c, 1'b1, ST_RANGE));
            else
                product_q.push_back(make_product(dot_product(r, c), c, 1'b1, ST_OK));
        end
        else if (r >= clamp_dim(dims.a_rows) || ncol == 0)
        begin
            product_q.push_back(make_product('0, 0, 1'b1, ST_RANGE));
        end
        else
        begin
            for (j = 0; j < ncol; j++)
                product_q.push_back(make_product(dot_product(r, j), j, j == ncol - 1, ST_OK));
        end
    endtask

    task automatic compare_field(input string name, input logic [ACC_W-1:0] want,
                                 input logic [ACC_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims = {4{DIM_RESET}};
            product_q.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (product_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result expected none got %0h col %0d last %b st %0d",
                             $time, product_value, out_col, last, status);
                end
                else
                begin
                    oldest = product_q.pop_front();
                    compare_field("product_value", oldest.prod, product_value);
                    compare_field("out_col", ACC_W'(oldest.col), ACC_W'(out_col));
                    compare_field("last", ACC_W'(oldest.last), ACC_W'(last));
                    compare_field("status", ACC_W'(oldest.st), ACC_W'(status));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A_ROWS: dims.a_rows = cfg_data;
                    CFG_A_COLS: dims.a_cols = cfg_data;
                    CFG_B_ROWS: dims.b_rows = cfg_data;
                    CFG_B_COLS: dims.b_cols = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_products(req_type, int'(row_index), int'(col_index), value);
            pending = product_q.size();
        end
    end

endmodule

>>> bench/tb_matrix_multiply_engine.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;

    import mme_pkg::*;

    localparam int MAX_DIM     = 64;
    localparam int HANG_LIMIT  = 2000;
    localparam int ITEM_TARGET = 180;
    localparam int SETTLE      = 8;
    localparam logic signed [VAL_W-1:0] MOST_NEG = 16'sh8000;
    localparam logic signed [VAL_W-1:0] MOST_POS = 16'sh7fff;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = CFG_A_ROWS;
    logic [DIM_W-1:0]            cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic [REQ_W-1:0]            req_type  = REQ_WR_A;
    logic [IN_IDX_W-1:0]         row_index = '0;
    logic [IN_IDX_W-1:0]         col_index = '0;
    logic signed [VAL_W-1:0]     value     = '0;
    logic                        out_ready = 1'b0;
    logic                        in_ready;
    logic                        out_valid;
    logic signed [ACC_W-1:0]     product_value;
    logic [COL_W-1:0]            out_col;
    logic                        last;
    logic [STATUS_W-1:0]         status;
    int                          pending;
    int                          errors;

    bit    calm = 1'b0;
    int    stall_count = 0;
    int    items_sent = 0;
    int    phase_no;
    dims_t dims_now = {4{DIM_RESET}};
    bit    a_written [0:MAX_DIM*MAX_DIM-1];
    bit    b_written [0:MAX_DIM*MAX_DIM-1];

    always #1 clk = ~clk;

    matrix_multiply_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .product_value (product_value),
        .out_col       (out_col),
        .last          (last),
        .status        (status)
    );

    mme_product_check #(.MAX_DIM(MAX_DIM)) product_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .product_value (product_value),
        .out_col       (out_col),
        .last          (last),
        .status        (status),
        .pending       (pending),
        .errors        (errors)
    );

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 33);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else if (stall_count >= HANG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    function automatic int clamp_dim(logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] rq, input int r, input int c,
                                input logic signed [VAL_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= rq;
        row_index <= r[IN_IDX_W-1:0];
        col_index <= c[IN_IDX_W-1:0];
        value     <= v;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic put_element(input logic [REQ_W-1:0] rq, input int r, input int c,
                               input logic signed [VAL_W-1:0] v);
        send_request(rq, r, c, v);
        if (rq == REQ_WR_A && r < clamp_dim(dims_now.a_rows) && c < clamp_dim(dims_now.a_cols))
            a_written[r*MAX_DIM+c] = 1'b1;
        else if (rq == REQ_WR_B && r < clamp_dim(dims_now.b_rows)
                 && c < clamp_dim(dims_now.b_cols))
            b_written[r*MAX_DIM+c] = 1'b1;
    endtask

    // write every operand the request will read that holds no value yet
    task automatic load_operands(input logic [REQ_W-1:0] rq, input int r, input int c,
                                 input bit heavy);
        int inner;
        int ncol;
        int lo;
        int hi;
        int k;
        int j;
        inner = clamp_dim(dims_now.a_cols);
        ncol  = clamp_dim(dims_now.b_cols);
        if (dims_now.a_cols != dims_now.b_rows || r >= clamp_dim(dims_now.a_rows))
            return;
        if (rq == REQ_ELEM)
        begin
            if (c >= ncol)
                return;
            lo = c;
            hi = c;
        end
        else
        begin
            if (ncol == 0)
                return;
            lo = 0;
            hi = ncol - 1;
        end
        for (k = 0; k < inner; k++)
        begin
            if (!a_written[r*MAX_DIM+k])
                put_element(REQ_WR_A, r, k, heavy ? MOST_NEG : pick_value());
            for (j = lo; j <= hi; j++)
                if (!b_written[k*MAX_DIM+j])
                    put_element(REQ_WR_B, k, j, heavy ? MOST_NEG : pick_value());
        end
    endtask

    task automatic ask_product(input logic [REQ_W-1:0] rq, input int r, input int c,
                               input bit heavy);
        load_operands(rq, r, c, heavy);
        send_request(rq, r, c, pick_value());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[DIM_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_dims(input int ar, input int ac, input int br, input int bc);
        drain();
        write_reg(CFG_A_ROWS, ar);
        write_reg(CFG_A_COLS, ac);
        write_reg(CFG_B_ROWS, br);
        write_reg(CFG_B_COLS, bc);
        cfg_we <= 1'b0;
        dims_now.a_rows = ar[DIM_W-1:0];
        dims_now.a_cols = ac[DIM_W-1:0];
        dims_now.b_rows = br[DIM_W-1:0];
        dims_now.b_cols = bc[DIM_W-1:0];
    endtask

    task automatic pick_dims();
        int kind;
        int inner;
        int ac;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            inner = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            set_dims($urandom_range(1, 5), inner, inner,
                     ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6));
        end
        else if (kind < 75)
        begin
            ac = $urandom_range(0, 127);
            set_dims($urandom_range(0, 5), ac, ac ^ $urandom_range(1, 127),
                     $urandom_range(0, 6));
        end
        else if (kind < 88)
            set_dims($urandom_range(0, 2), 0, 0, $urandom_range(0, 3));
        else
            set_dims($urandom_range(65, 127), 1, 1, $urandom_range(65, 127));
    endtask

    task automatic run_phase(input bit heavy);
        int ops;
        int n;
        int pick;
        int r;
        int c;
        int nr;
        int nc;
        logic [REQ_W-1:0] rq;
        ops = heavy ? 6 : $urandom_range(10, 20);
        for (n = 0; n < ops && items_sent < ITEM_TARGET; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                drain();
            if (pick < 55)
            begin
                rq = ($urandom_range(0, 2) == 0) ? REQ_ROW : REQ_ELEM;
                nr = clamp_dim(dims_now.a_rows);
                nc = clamp_dim(dims_now.b_cols);
            end
            else
            begin
                rq = $urandom_range(0, 1) ? REQ_WR_B : REQ_WR_A;
                nr = clamp_dim((rq == REQ_WR_A) ? dims_now.a_rows : dims_now.b_rows);
                nc = clamp_dim((rq == REQ_WR_A) ? dims_now.a_cols : dims_now.b_cols);
            end
            if (pick < 85 && $urandom_range(0, 4) != 0 && nr > 0 && nc > 0)
            begin
                r = $urandom_range(0, nr - 1);
                c = $urandom_range(0, nc - 1);
            end
            else
            begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
            end
            if (pick < 55)
                ask_product(rq, r, c, heavy);
            else
                put_element(rq, r, c, pick_value());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        put_element(REQ_WR_A, 63, 63, MOST_POS);
        set_dims(2, 1, 1, 2);
        put_element(REQ_WR_A, 0, 0, MOST_NEG);
        put_element(REQ_WR_A, 1, 0, MOST_POS);
        put_element(REQ_WR_B, 0, 0, MOST_NEG);
        put_element(REQ_WR_B, 0, 1, MOST_POS);
        ask_product(REQ_ELEM, 0, 0, 1'b0);
        ask_product(REQ_ELEM, 1, 1, 1'b0);
        ask_product(REQ_ELEM, 1, 0, 1'b0);
        ask_product(REQ_ROW, 0, 63, 1'b0);
        ask_product(REQ_ROW, 1, 0, 1'b0);
        ask_product(REQ_ELEM, 2, 0, 1'b0);
        ask_product(REQ_ELEM, 0, 2, 1'b0);
        ask_product(REQ_ELEM, 63, 63, 1'b0);
        ask_product(REQ_ROW, 63, 0, 1'b0);
        put_element(REQ_WR_A, 5, 5, MOST_NEG);
        put_element(REQ_WR_B, 63, 63, MOST_NEG);
        ask_product(REQ_ELEM, 0, 0, 1'b0);

        set_dims(2, 1, 3, 2);
        ask_product(REQ_ELEM, 0, 1, 1'b0);
        ask_product(REQ_ROW, 1, 5, 1'b0);

        set_dims(2, 1, 1, 0);
        ask_product(REQ_ROW, 0, 0, 1'b0);
        ask_product(REQ_ELEM, 0, 0, 1'b0);

        set_dims(1, 127, 127, 1);
        ask_product(REQ_ELEM, 0, 0, 1'b1);
        ask_product(REQ_ROW, 0, 0, 1'b1);

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick_dims();
            calm = (phase_no == 0);
            run_phase(1'b0);
            phase_no++;
        end

        drain();
        calm = 1'b0;
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
